// ===== design/atm_pkg.sv =====
// Shared types and constants for the adaptive throughput meter.
package atm_pkg;

    localparam int DATA_W  = 32;
    localparam int DIV_NW  = 49;
    localparam int DIV_DW  = 16;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);
    localparam int HC_W    = 5;
    localparam int CFG_IW  = 4;
    localparam int CFG_DW  = 16;

    localparam logic [9:0]        MS_PER_S     = 10'd1000;
    localparam logic [3:0]        DEPTH_RESET  = 4'd5;
    localparam logic [15:0]       WINDOW_RESET = 16'd1000;
    localparam logic [CFG_IW-1:0] CFG_DEPTH    = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_WINDOW   = 4'd1;

    typedef enum logic [1:0] {
        K_BYTES   = 2'd0,
        K_TIME    = 2'd1,
        K_RESTART = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPEED,
        S_CHECK,
        S_CMP_RD,
        S_CMP_CHK,
        S_CMP_END,
        S_RATE_MUL,
        S_RATE_GO,
        S_RATE_WAIT,
        S_STORE,
        S_MEAN_MUL,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/adaptive_throughput_meter.sv =====
// Adaptive throughput meter: sequencer, accumulators and output register.
// One item at a time; the next is taken once the current result is in the output register.
// A mean result skips the divider; an instantaneous rate uses it once, and a window close
// uses it twice, after comparing the history with the mean when more than depth samples are held.
// The 49-step divider is shared by both divisions.
// Reset (i_rst_n low, synchronous) clears accumulators, mean and counts and loads depth 5,
// window 1000 ms; the history memory is not cleared and needs no clearing pass.
module adaptive_throughput_meter #(
    parameter int HISTORY_SLOTS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_byte_count,
    input  logic [9:0]  i_tick_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_speed,
    output logic        o_window_closed,
    output logic        o_averaged,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [atm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [atm_pkg::CFG_DW-1:0] i_cfg_data
);
    import atm_pkg::*;

    localparam int            HIST_AW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
    localparam logic [HC_W-1:0] SLOTS_V = HC_W'(HISTORY_SLOTS);

    t_state r_state;
    t_state n_state;

    logic [3:0]        r_depth;
    logic [15:0]       r_window;
    logic [HC_W-1:0]   r_hc;
    logic [DATA_W-1:0] r_mean;
    logic [15:0]       r_mcount;
    logic [DATA_W-1:0] r_bytes;
    logic [15:0]       r_elapsed;

    logic              r_closed;
    logic              r_avg;
    logic [DATA_W-1:0] r_speed;
    logic [DATA_W-1:0] r_sample;
    logic [DIV_NW-1:0] r_prod;
    logic [HC_W-1:0]   r_idx;
    logic              r_above;
    logic              r_below;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_speed;
    logic              r_out_closed;
    logic              r_out_avg;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic              w_hist_we;
    logic [HIST_AW-1:0] w_hist_waddr;
    logic [HIST_AW-1:0] w_hist_raddr;
    logic [DATA_W-1:0] w_hist_rdata;

    logic              w_in_acc;
    logic              w_cfg_acc;
    logic              w_out_free;
    logic [16:0]       w_el_sum;
    logic [15:0]       w_el_new;
    logic [32:0]       w_by_sum;
    logic              w_closing;
    logic [HC_W-1:0]   w_lim;
    logic [HC_W-1:0]   w_idx_nxt;
    logic [41:0]       w_rate_prod;
    logic [47:0]       w_mean_prod;
    logic [15:0]       w_mc_m1;
    logic [DATA_W-1:0] w_q_sat;

    atm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    atm_hist #(
        .SLOTS (HISTORY_SLOTS),
        .AW    (HIST_AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_hist_we),
        .i_wr_addr (w_hist_waddr),
        .i_wr_data (r_sample),
        .i_rd_addr (w_hist_raddr),
        .o_rd_data (w_hist_rdata)
    );

    // a pending register write goes first
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        w_el_sum    = {1'b0, r_elapsed} + 17'(i_tick_ms);
        w_el_new    = w_el_sum[16] ? 16'hFFFF : w_el_sum[15:0];
        w_by_sum    = {1'b0, r_bytes} + 33'(i_byte_count);
        w_closing   = (i_kind == K_TIME) && (w_el_new > r_window);
        w_lim       = ({1'b0, r_depth} < SLOTS_V) ? {1'b0, r_depth} : SLOTS_V;
        w_idx_nxt   = r_idx + HC_W'(1);
        w_rate_prod = 42'(r_bytes) * 42'(MS_PER_S);
        w_mc_m1     = r_mcount - 16'd1;
        w_mean_prod = 48'(r_mean) * 48'(w_mc_m1);
        w_q_sat     = (|w_div_rsp.quotient[DIV_NW-1:DATA_W]) ? '1
                    : w_div_rsp.quotient[DATA_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_closing ? S_CHECK : S_SPEED;
                end
            end
            S_SPEED: begin
                if (r_hc != '0 || r_elapsed == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RATE_MUL;
                end
            end
            S_CHECK: begin
                if (r_hc > {1'b0, r_depth}) begin
                    n_state = (w_lim == '0) ? S_CMP_END : S_CMP_RD;
                end else begin
                    n_state = S_RATE_MUL;
                end
            end
            S_CMP_RD:    n_state = S_CMP_CHK;
            S_CMP_CHK:   n_state = (w_idx_nxt < w_lim) ? S_CMP_RD : S_CMP_END;
            S_CMP_END:   n_state = S_RATE_MUL;
            S_RATE_MUL:  n_state = S_RATE_GO;
            S_RATE_GO:   n_state = S_RATE_WAIT;
            S_RATE_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = r_closed ? S_STORE : S_OUT;
                end
            end
            S_STORE:     n_state = S_MEAN_MUL;
            S_MEAN_MUL:  n_state = S_MEAN_GO;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_div_req.start    = (r_state == S_RATE_GO) || (r_state == S_MEAN_GO);
        w_div_req.dividend = (r_state == S_MEAN_GO) ? r_prod + DIV_NW'(r_sample) : r_prod;
        w_div_req.divisor  = (r_state == S_MEAN_GO) ? r_mcount : r_elapsed;
        w_hist_we          = (r_state == S_STORE) && (r_hc < SLOTS_V);
        w_hist_waddr       = r_hc[HIST_AW-1:0];
        w_hist_raddr       = r_idx[HIST_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= DEPTH_RESET;
            r_window  <= WINDOW_RESET;
            r_hc      <= '0;
            r_mean    <= '0;
            r_mcount  <= '0;
            r_bytes   <= '0;
            r_elapsed <= '0;
        end else begin
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_DEPTH: begin
                        if ({1'b0, i_cfg_data[3:0]} < SLOTS_V) begin
                            r_depth <= i_cfg_data[3:0];
                            r_hc    <= '0;
                            r_mean  <= '0;
                        end
                    end
                    CFG_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (t_kind'(i_kind))
                            K_BYTES: r_bytes <= w_by_sum[32] ? '1 : w_by_sum[31:0];
                            K_TIME:  r_elapsed <= w_el_new;
                            K_RESTART: begin
                                r_bytes   <= '0;
                                r_elapsed <= '0;
                                r_hc      <= '0;
                                r_mean    <= '0;
                                r_mcount  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CMP_END: begin
                    if (r_above || r_below) begin
                        r_mcount <= '0;
                    end
                    r_hc <= '0;
                end
                S_STORE: begin
                    r_hc <= r_hc + HC_W'(1);
                    if (r_mcount == '0) begin
                        r_mean <= r_sample;
                    end
                    if (r_mcount != 16'hFFFF) begin
                        r_mcount <= r_mcount + 16'd1;
                    end
                end
                S_MEAN_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_mean    <= w_div_rsp.quotient[DATA_W-1:0];
                        r_bytes   <= '0;
                        r_elapsed <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_closed <= w_closing;
                end
            end
            S_SPEED: begin
                r_avg   <= (r_hc != '0);
                r_speed <= (r_hc != '0) ? r_mean : '0;
            end
            S_CHECK: begin
                r_idx   <= '0;
                r_above <= 1'b1;
                r_below <= 1'b1;
            end
            S_CMP_CHK: begin
                if (w_hist_rdata < r_mean) begin
                    r_above <= 1'b0;
                end
                if (w_hist_rdata > r_mean) begin
                    r_below <= 1'b0;
                end
                r_idx <= w_idx_nxt;
            end
            S_RATE_MUL: r_prod <= DIV_NW'(w_rate_prod);
            S_RATE_WAIT: begin
                if (w_div_rsp.done) begin
                    r_sample <= w_q_sat;
                    r_speed  <= w_q_sat;
                    r_avg    <= 1'b0;
                end
            end
            S_MEAN_MUL: r_prod <= DIV_NW'(w_mean_prod);
            S_MEAN_WAIT: begin
                if (w_div_rsp.done) begin
                    r_speed <= w_div_rsp.quotient[DATA_W-1:0];
                    r_avg   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_speed  <= r_speed;
            r_out_closed <= r_closed;
            r_out_avg    <= r_avg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed         = r_out_speed;
    assign o_window_closed = r_out_closed;
    assign o_averaged      = r_out_avg;

`ifndef NO_ASSERTIONS
    a_closed_is_averaged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_window_closed || o_averaged))
        else $error("closed window reported without mean");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_mean_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAN_GO) |-> (r_mcount != '0))
        else $error("mean update with zero count");

    a_rate_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RATE_GO) |-> (r_elapsed != '0))
        else $error("rate division with zero elapsed time");
`endif

endmodule

// ===== design/atm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module atm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atm_pkg::t_div_req i_req,
    output atm_pkg::t_div_rsp o_rsp
);
    import atm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_dvs;

    logic [DIV_DW:0]   w_rem_sh;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;
    logic [DIV_DW-1:0] n_rem;
    logic [DIV_NW-1:0] n_quo;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_NW-1]};
        w_ge     = w_rem_sh >= {1'b0, r_dvs};
        w_diff   = w_rem_sh - {1'b0, r_dvs};
        n_rem    = w_ge ? w_diff[DIV_DW-1:0] : w_rem_sh[DIV_DW-1:0];
        n_quo    = {r_quo[DIV_NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== design/atm_hist.sv =====
// Window sample history memory with registered read.
module atm_hist #(
    parameter int SLOTS = 10,
    parameter int AW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [atm_pkg::DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [atm_pkg::DATA_W-1:0] o_rd_data
);
    import atm_pkg::*;

    logic [DATA_W-1:0] r_mem [SLOTS];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the adaptive throughput meter: predicts every speed result.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import atm_pkg::*;

    localparam int          HIST_SLOTS   = 10;
    localparam logic [1:0]  K_UNUSED     = 2'd3;
    localparam int          PRESS_AT     = 600;
    localparam int          PRESS_CYCLES = 500;
    localparam int          TREND_RANDOM  = 0;
    localparam int          TREND_RISING  = 1;
    localparam int          TREND_FALLING = 2;
    localparam int          TREND_FLAT    = 3;

    typedef struct packed {
        logic [31:0] speed;
        logic        closed;
        logic        averaged;
    } t_speed_result;

    class t_speed_tracker;
        logic [31:0]   hist [HIST_SLOTS];
        int unsigned   hist_cnt;
        logic [31:0]   mean;
        logic [15:0]   mean_n;
        logic [31:0]   bytes_sum;
        logic [15:0]   elapsed_ms;
        logic [3:0]    depth;
        logic [15:0]   window;
        t_speed_result due_speeds[$];
        int            errors;
        int            results_seen;
        int            windows;
        int            averaged_seen;
        int            mean_restarts;

        function new();
            int i;
            for (i = 0; i < HIST_SLOTS; i++) hist[i] = '0;
            hist_cnt = 0;
            mean = '0;
            mean_n = '0;
            bytes_sum = '0;
            elapsed_ms = '0;
            depth = DEPTH_RESET;
            window = WINDOW_RESET;
            errors = 0;
            results_seen = 0;
            windows = 0;
            averaged_seen = 0;
            mean_restarts = 0;
        endfunction

        function int pending();
            return due_speeds.size();
        endfunction

        function logic [31:0] rate_now();
            longint unsigned q;
            if (elapsed_ms == 0) return 32'd0;
            q = 64'(bytes_sum);
            q = q * 64'd1000 / 64'(elapsed_ms);
            return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        function void close_window();
            int i;
            bit above;
            bit below;
            logic [31:0] sample;
            longint unsigned acc;
            above = 1'b1;
            below = 1'b1;
            if (hist_cnt > depth) begin
                for (i = 0; i < depth && i < HIST_SLOTS; i++) begin
                    if (hist[i] < mean) above = 1'b0;
                    if (hist[i] > mean) below = 1'b0;
                end
                if (above || below) begin
                    mean_n = '0;
                    mean_restarts++;
                end
                hist_cnt = 0;
            end
            sample = rate_now();
            if (hist_cnt < HIST_SLOTS) hist[hist_cnt] = sample;
            hist_cnt++;
            if (mean_n == 0) mean = sample;
            if (mean_n != 16'hFFFF) mean_n++;
            acc = 64'(mean);
            acc = (acc * 64'(mean_n - 16'd1) + 64'(sample)) / 64'(mean_n);
            mean = acc[31:0];
            bytes_sum = '0;
            elapsed_ms = '0;
            windows++;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_DEPTH) begin
                if (data[3:0] < HIST_SLOTS) begin
                    depth = data[3:0];
                    hist_cnt = 0;
                    mean = '0;
                end
            end else if (idx == CFG_WINDOW) begin
                window = data;
            end
        endfunction

        function void take_item(logic [1:0] kind, logic [15:0] bc, logic [9:0] tick);
            longint unsigned sum;
            t_speed_result r;
            r.closed = 1'b0;
            case (kind)
                K_BYTES: begin
                    sum = 64'(bytes_sum);
                    sum += 64'(bc);
                    bytes_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
                K_TIME: begin
                    sum = 64'(elapsed_ms);
                    sum += 64'(tick);
                    elapsed_ms = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
                    if (elapsed_ms > window) begin
                        close_window();
                        r.closed = 1'b1;
                    end
                end
                K_RESTART: begin
                    bytes_sum = '0;
                    elapsed_ms = '0;
                    hist_cnt = 0;
                    mean = '0;
                    mean_n = '0;
                end
                default: ;
            endcase
            r.averaged = (hist_cnt > 0);
            r.speed = r.averaged ? mean : rate_now();
            if (r.averaged) averaged_seen++;
            due_speeds.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH at result %0d: %s", results_seen, msg);
        endtask

        task check_speed(logic [31:0] speed, logic closed, logic averaged);
            t_speed_result want;
            results_seen++;
            if (due_speeds.size() == 0) begin
                flag_mismatch($sformatf("result with no transfer pending, speed %0d", speed));
                return;
            end
            want = due_speeds.pop_front();
            if (speed !== want.speed)
                flag_mismatch($sformatf("speed %0d, want %0d", speed, want.speed));
            if (closed !== want.closed)
                flag_mismatch($sformatf("window_closed %b, want %b", closed, want.closed));
            if (averaged !== want.averaged)
                flag_mismatch($sformatf("averaged %b, want %b", averaged, want.averaged));
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        in_kind   = '0;
    logic [15:0]       in_bytes  = '0;
    logic [9:0]        in_tick   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [31:0]       out_speed;
    logic              out_closed;
    logic              out_averaged;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    logic              press_req  = 1'b0;
    logic              press_done = 1'b0;
    int                rx_hold    = 0;
    int                tx_quiet   = 0;
    bit                no_gaps    = 1'b0;
    int                items_sent = 0;
    t_speed_tracker    tracker;

    adaptive_throughput_meter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (in_kind),
        .i_byte_count    (in_bytes),
        .i_tick_ms       (in_tick),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_speed         (out_speed),
        .o_window_closed (out_closed),
        .o_averaged      (out_averaged),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stall bursts plus one long hold-off
    always @(posedge clk) begin
        int r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (press_req && !press_done) begin
            out_stall <= 1'b1;
            rx_hold <= PRESS_CYCLES;
            press_done <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                out_stall <= 1'b0;
                rx_hold <= $urandom_range(0, 19);
            end else if (r < 90) begin
                out_stall <= 1'b1;
                rx_hold <= $urandom_range(0, 3);
            end else if (r < 97) begin
                out_stall <= 1'b1;
                rx_hold <= $urandom_range(10, 40);
            end else begin
                out_stall <= 1'b0;
                rx_hold <= $urandom_range(50, 150);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_speed(out_speed, out_closed, out_averaged);
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        if (tx_quiet > 0) begin
            tx_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        if (r < 98) return $urandom_range(20, 60);
        tx_quiet = $urandom_range(20, 80);
        return 0;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [15:0] b, input logic [9:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_bytes <= b;
        in_tick  <= t;
        do @(posedge clk); while (in_stall);
        tracker.take_item(k, b, t);
        items_sent++;
        if (items_sent == PRESS_AT) press_req <= 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    // registers change only with nothing in flight
    task automatic configure(input logic [3:0] depth, input logic [15:0] window);
        logic [11:0] junk;
        junk = 12'($urandom);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        write_reg(CFG_DEPTH, {junk, depth});
        write_reg(CFG_WINDOW, window);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_bytes();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] random_tick();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'($urandom_range(0, 31));
            default: return 10'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count, input int trend);
        int n;
        int i;
        int nb;
        int r;
        int guard;
        int w0;
        int level;
        logic [9:0] t;
        n = 0;
        level = $urandom_range(0, 65535);
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom), 10'($urandom));
                n++;
            end else if (r < 10) begin
                send_item(K_RESTART, 16'($urandom), 10'($urandom));
                n++;
            end else begin
                case (trend)
                    TREND_RISING: begin
                        level += $urandom_range(1, 3000);
                        if (level > 65535) level = $urandom_range(0, 2000);
                    end
                    TREND_FALLING: begin
                        level -= $urandom_range(1, 3000);
                        if (level < 0) level = $urandom_range(60000, 65535);
                    end
                    default: ;
                endcase
                nb = (trend == TREND_RANDOM) ? $urandom_range(0, 4) : 2;
                for (i = 0; i < nb; i++) begin
                    if (trend == TREND_RANDOM && $urandom_range(0, 49) == 0)
                        send_item(K_RESTART, 16'($urandom), 10'($urandom));
                    else
                        send_item(K_BYTES, (trend == TREND_RANDOM) ? random_bytes() : level[15:0],
                                  10'($urandom));
                    n++;
                end
                w0 = tracker.windows;
                guard = 0;
                do begin
                    t = (trend == TREND_RANDOM) ? random_tick() : 10'd1023;
                    send_item(K_TIME, 16'($urandom), t);
                    n++;
                    guard++;
                end while (tracker.windows == w0 && guard < 70);
            end
        end
    endtask

    task automatic saturation_runs();
        no_gaps = 1'b1;
        configure(4'd9, 16'd1);
        send_item(K_RESTART, 16'($urandom), 10'($urandom));
        send_item(K_TIME, 16'($urandom), 10'd1);
        repeat (70) send_item(K_BYTES, 16'hFFFF, 10'($urandom));
        send_item(K_TIME, 16'($urandom), 10'd1);
        send_item(K_TIME, 16'($urandom), 10'd1);
        send_item(K_TIME, 16'($urandom), 10'd1);
        configure(4'd9, 16'd65535);
        send_item(K_RESTART, 16'($urandom), 10'($urandom));
        repeat (66) send_item(K_TIME, 16'($urandom), 10'd1023);
        send_item(K_BYTES, 16'hFFFF, 10'($urandom));
        send_item(K_TIME, 16'($urandom), 10'd1023);
        no_gaps = 1'b0;
    endtask

    initial begin
        #150_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int ph;
        logic [3:0] d;
        logic [15:0] w;
        int tr;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, zero elapsed, window edge, unused kind, restart
        send_item(K_BYTES, 16'h0000, 10'h3FF);
        send_item(K_TIME, 16'hFFFF, 10'd0);
        send_item(K_BYTES, 16'hFFFF, 10'h000);
        send_item(K_TIME, 16'h0000, 10'd1);
        send_item(K_UNUSED, 16'hFFFF, 10'h3FF);
        send_item(K_TIME, 16'hAAAA, 10'd999);
        send_item(K_TIME, 16'h5555, 10'd1);
        send_item(K_BYTES, 16'h8000, 10'h155);
        send_item(K_TIME, 16'h0001, 10'd1023);
        send_item(K_RESTART, 16'hFFFF, 10'h3FF);
        send_item(K_TIME, 16'h0000, 10'd1023);
        send_item(K_BYTES, 16'h7FFF, 10'h2AA);
        configure(4'd0, 16'd1);
        send_item(K_TIME, 16'h0F0F, 10'd2);
        send_item(K_BYTES, 16'h1234, 10'h0F0);
        send_item(K_TIME, 16'hF0F0, 10'd2);
        send_item(K_TIME, 16'h0000, 10'd1);
        configure(4'd15, 16'd1);
        send_item(K_TIME, 16'h0000, 10'd1);
        send_item(K_UNUSED, 16'h0000, 10'h000);
        configure(4'd9, 16'd2);
        send_item(K_BYTES, 16'hFFFF, 10'h3FF);
        send_item(K_TIME, 16'h0000, 10'd3);
        send_item(K_RESTART, 16'h0000, 10'h000);
        send_item(K_BYTES, 16'h0001, 10'h000);

        for (ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin d = 4'd5;  w = 16'd1000;  tr = TREND_RANDOM;  end
                1: begin d = 4'd0;  w = 16'd1;     tr = TREND_RANDOM;  end
                2: begin d = 4'd9;  w = 16'd65535; tr = TREND_RANDOM;  end
                3: begin d = 4'd3;  w = 16'd1500;  tr = TREND_FLAT;    end
                4: begin d = 4'd9;  w = 16'd800;   tr = TREND_FLAT;    end
                5: begin d = 4'd2;  w = 16'd2047;  tr = TREND_RISING;  end
                6: begin d = 4'd4;  w = 16'd1200;  tr = TREND_FALLING; end
                7: begin d = 4'd1;  w = 16'd300;   tr = TREND_RANDOM;  end
                8: begin d = 4'd12; w = 16'($urandom_range(1, 4000)); tr = TREND_RANDOM; end
                9: begin d = 4'd6;  w = 16'($urandom_range(1, 3000)); tr = TREND_FLAT;   end
                10: begin d = 4'd8; w = 16'($urandom_range(1, 1023)); tr = TREND_RISING; end
                default: begin
                    d = 4'($urandom_range(0, 15));
                    w = 16'($urandom_range(1, 65535));
                    tr = TREND_RANDOM;
                end
            endcase
            configure(d, w);
            random_phase(130, tr);
        end

        saturation_runs();

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Run covered %0d transfers in, %0d results, %0d window closes, %0d mean restarts",
                 items_sent, tracker.results_seen, tracker.windows, tracker.mean_restarts);
        $display("%0d averaged results; depths 0 to 15, windows 1 to 65535, saturation and hold-off",
                 tracker.averaged_seen);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
